// ===== rtl/ctq_pkg.sv =====
package ctq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLOSE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    RULE_APPEND  = 3'd0,
    RULE_PREPEND = 3'd1,
    RULE_OWNER   = 3'd2,
    RULE_TASK    = 3'd3,
    RULE_BOTH    = 3'd4
  } rule_e;

  typedef enum logic [2:0] {
    KIND_ACCEPT     = 3'd0,
    KIND_REJ_CLOSED = 3'd1,
    KIND_REJ_FULL   = 3'd2,
    KIND_CANCEL     = 3'd3,
    KIND_POPPED     = 3'd4,
    KIND_POP_EMPTY  = 3'd5,
    KIND_CLOSE_DONE = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_CLOSE
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_COMPACT,
    ST_CLEAR,
    ST_FINAL
  } back_state_e;

  typedef enum logic [2:0] {
    FIN_REJ_CLOSED,
    FIN_INSERT,
    FIN_ACCEPT,
    FIN_POP,
    FIN_CLOSE
  } fin_e;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] owner;
    logic [15:0] tsk;
  } entry_t;

  typedef struct packed {
    op_e    op;
    rule_e  rule;
    logic   clear;
    entry_t ent;
  } op_t;

endpackage

// ===== rtl/ctq_if.sv =====
interface ctq_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  push_rule;
  logic [15:0] owner_id;
  logic [15:0] task_id;
  logic [15:0] task_handle;
  logic        clear_on_close;

  modport source (output valid, action, push_rule, owner_id, task_id, task_handle,
                  clear_on_close, input ready);
  modport sink (input valid, action, push_rule, owner_id, task_id, task_handle,
                clear_on_close, output ready);
endinterface

interface ctq_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] out_handle;
  logic [15:0] out_owner;
  logic [15:0] out_task;
  logic        last;
  logic        queue_closed;
  logic [4:0]  entry_count;

  modport source (output valid, kind, out_handle, out_owner, out_task, last,
                  queue_closed, entry_count, input ready);
  modport sink (input valid, kind, out_handle, out_owner, out_task, last,
                queue_closed, entry_count, output ready);
endinterface

// ===== rtl/coalescing_task_queue_top.sv =====
// Ordered task queue with coalescing pushes, 16 entries deep.
// Commands arrive on cmd_i as valid/ready transfers: push, pop or close.
// Results leave on res_o as valid/ready transfers; every command gives one
// or more results, the final one marked by last. Commands with action code
// 3 are taken and dropped without any result.
// A two-entry command queue decouples the intake from the execution engine,
// so commands keep being taken while results wait on a stalled receiver.
// A push with append or prepend, a pop, a push to a closed queue and a plain
// close go straight to the final state. A close with clearing first sweeps the
// entries, cancelling each. A coalescing push counts matches in one sweep over
// the entries and compacts them in a second; with no match it skips the second.
// The engine handles one command at a time and takes no new command until the
// final result of the last one has been issued.
// Reset empties the queue, clears the closed flag and drops pending results.
// When the receiver stalls, the engine holds in place and loses nothing.
module coalescing_task_queue_top
  import ctq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  ctq_cmd_if.sink   cmd_i,
  ctq_res_if.source res_o
);

  logic op_valid;
  logic op_take;
  op_t  op;

  ctq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_take_i  (op_take)
  );

  ctq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_take_o  (op_take),
    .res_o      (res_o)
  );

endmodule

// ===== rtl/ctq_front.sv =====
module ctq_front
  import ctq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ctq_cmd_if.sink    cmd_i,
  output logic       op_valid_o,
  output op_t        op_o,
  input  logic       op_take_i
);

  op_t        mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  op_t        dec;
  logic       known;
  logic       push;

  always_comb begin
    dec            = '0;
    known          = 1'b1;
    dec.clear      = cmd_i.clear_on_close;
    dec.ent.handle = cmd_i.task_handle;
    dec.ent.owner  = cmd_i.owner_id;
    dec.ent.tsk    = cmd_i.task_id;
    case (cmd_i.action)
      ACT_PUSH:  dec.op = OP_PUSH;
      ACT_POP:   dec.op = OP_POP;
      ACT_CLOSE: dec.op = OP_CLOSE;
      default: begin
        dec.op = OP_POP;
        known  = 1'b0;
      end
    endcase
    case (cmd_i.push_rule)
      RULE_PREPEND: dec.rule = RULE_PREPEND;
      RULE_OWNER:   dec.rule = RULE_OWNER;
      RULE_TASK:    dec.rule = RULE_TASK;
      RULE_BOTH:    dec.rule = RULE_BOTH;
      default:      dec.rule = RULE_APPEND;
    endcase
  end

  assign cmd_i.ready = (cnt_q != 2'd2);
  assign push        = cmd_i.valid && cmd_i.ready && known;
  assign op_valid_o  = (cnt_q != 2'd0);
  assign op_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (op_take_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(op_take_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= dec;
  end

endmodule

// ===== rtl/ctq_back.sv =====
module ctq_back
  import ctq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       op_valid_i,
  input  op_t        op_i,
  output logic       op_take_o,
  ctq_res_if.source  res_o
);

  back_state_e state_q, state_d;
  fin_e        fin_q, fin_d;
  op_t         cmd_q, cmd_d;
  logic [CNT_W-1:0] i_q, i_d, w_q, w_d, cnt_q, cnt_d, occ_q, occ_d;
  logic        first_q, first_d;
  logic        closed_q, closed_d;
  entry_t      ent_q [DEPTH];

  logic        out_valid_q;
  kind_e       out_kind_q;
  entry_t      out_ent_q;
  logic        out_last_q, out_closed_q;
  logic [CNT_W-1:0] out_cnt_q;

  logic        slot_free;
  logic        emit;
  kind_e       e_kind;
  entry_t      e_ent;
  logic        e_last;
  logic [CNT_W-1:0] e_cnt;

  logic        wr_en, shift_up, shift_down;
  logic [IDX_W-1:0] wr_idx;
  entry_t      wr_data;

  entry_t      rd;
  logic        by_owner, by_task, match, in_range;

  assign slot_free = !out_valid_q || res_o.ready;
  assign rd        = ent_q[i_q[IDX_W-1:0]];
  assign by_owner  = (cmd_q.rule == RULE_OWNER) || (cmd_q.rule == RULE_BOTH);
  assign by_task   = (cmd_q.rule == RULE_TASK) || (cmd_q.rule == RULE_BOTH);
  assign match     = (!by_owner || rd.owner == cmd_q.ent.owner) &&
                     (!by_task || rd.tsk == cmd_q.ent.tsk);
  assign in_range  = (i_q < occ_q);

  always_comb begin
    state_d    = state_q;
    fin_d      = fin_q;
    cmd_d      = cmd_q;
    i_d        = i_q;
    w_d        = w_q;
    cnt_d      = cnt_q;
    occ_d      = occ_q;
    first_d    = first_q;
    closed_d   = closed_q;
    op_take_o  = 1'b0;
    emit       = 1'b0;
    e_kind     = KIND_ACCEPT;
    e_ent      = '0;
    e_last     = 1'b0;
    e_cnt      = occ_q;
    wr_en      = 1'b0;
    wr_idx     = w_q[IDX_W-1:0];
    wr_data    = rd;
    shift_up   = 1'b0;
    shift_down = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          op_take_o = 1'b1;
          cmd_d     = op_i;
          i_d       = '0;
          cnt_d     = '0;
          case (op_i.op)
            OP_PUSH: begin
              if (closed_q) begin
                fin_d   = FIN_REJ_CLOSED;
                state_d = ST_FINAL;
              end else if (op_i.rule == RULE_OWNER || op_i.rule == RULE_TASK ||
                           op_i.rule == RULE_BOTH) begin
                state_d = ST_COUNT;
              end else begin
                fin_d   = FIN_INSERT;
                state_d = ST_FINAL;
              end
            end
            OP_POP: begin
              fin_d   = FIN_POP;
              state_d = ST_FINAL;
            end
            default: begin
              closed_d = 1'b1;
              if (op_i.clear) begin
                state_d = ST_CLEAR;
              end else begin
                fin_d   = FIN_CLOSE;
                state_d = ST_FINAL;
              end
            end
          endcase
        end
      end
      ST_COUNT: begin
        if (in_range) begin
          if (match) cnt_d = cnt_q + 1'b1;
          i_d = i_q + 1'b1;
        end else if (cnt_q != '0) begin
          i_d     = '0;
          w_d     = '0;
          first_d = 1'b0;
          state_d = ST_COMPACT;
        end else begin
          fin_d   = FIN_INSERT;
          state_d = ST_FINAL;
        end
      end
      ST_COMPACT: begin
        if (in_range) begin
          if (match) begin
            if (slot_free) begin
              emit   = 1'b1;
              e_kind = KIND_CANCEL;
              e_ent  = rd;
              e_cnt  = occ_q - cnt_q + 1'b1;
              if (!first_q) begin
                wr_en   = 1'b1;
                wr_data = cmd_q.ent;
                w_d     = w_q + 1'b1;
                first_d = 1'b1;
              end
              i_d = i_q + 1'b1;
            end
          end else begin
            wr_en = 1'b1;
            w_d   = w_q + 1'b1;
            i_d   = i_q + 1'b1;
          end
        end else begin
          occ_d   = w_q;
          fin_d   = FIN_ACCEPT;
          state_d = ST_FINAL;
        end
      end
      ST_CLEAR: begin
        if (in_range) begin
          if (slot_free) begin
            emit   = 1'b1;
            e_kind = KIND_CANCEL;
            e_ent  = rd;
            e_cnt  = '0;
            i_d    = i_q + 1'b1;
          end
        end else begin
          occ_d   = '0;
          fin_d   = FIN_CLOSE;
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_last  = 1'b1;
          state_d = ST_IDLE;
          case (fin_q)
            FIN_REJ_CLOSED: e_kind = KIND_REJ_CLOSED;
            FIN_INSERT: begin
              if (occ_q >= CNT_W'(DEPTH)) begin
                e_kind = KIND_REJ_FULL;
              end else begin
                e_kind = KIND_ACCEPT;
                if (cmd_q.rule == RULE_PREPEND) begin
                  shift_up = 1'b1;
                end else begin
                  wr_en  = 1'b1;
                  wr_idx = occ_q[IDX_W-1:0];
                end
                wr_data = cmd_q.ent;
                occ_d   = occ_q + 1'b1;
                e_cnt   = occ_q + 1'b1;
              end
            end
            FIN_ACCEPT: e_kind = KIND_ACCEPT;
            FIN_POP: begin
              if (occ_q == '0) begin
                e_kind = KIND_POP_EMPTY;
              end else begin
                e_kind     = KIND_POPPED;
                e_ent      = ent_q[0];
                shift_down = 1'b1;
                occ_d      = occ_q - 1'b1;
                e_cnt      = occ_q - 1'b1;
              end
            end
            default: e_kind = KIND_CLOSE_DONE;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      closed_q <= closed_d;
      if (emit) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q   <= fin_d;
    cmd_q   <= cmd_d;
    i_q     <= i_d;
    w_q     <= w_d;
    cnt_q   <= cnt_d;
    first_q <= first_d;
    if (emit) begin
      out_kind_q   <= e_kind;
      out_ent_q    <= e_ent;
      out_last_q   <= e_last;
      out_closed_q <= closed_q;
      out_cnt_q    <= e_cnt;
    end
    if (shift_down) begin
      for (int k = 0; k < DEPTH - 1; k++) ent_q[k] <= ent_q[k+1];
    end
    if (shift_up) begin
      for (int k = 1; k < DEPTH; k++) ent_q[k] <= ent_q[k-1];
      ent_q[0] <= wr_data;
    end
    if (wr_en) ent_q[wr_idx] <= wr_data;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = out_kind_q;
  assign res_o.out_handle   = out_ent_q.handle;
  assign res_o.out_owner    = out_ent_q.owner;
  assign res_o.out_task     = out_ent_q.tsk;
  assign res_o.last         = out_last_q;
  assign res_o.queue_closed = out_closed_q;
  assign res_o.entry_count  = 5'(out_cnt_q);

endmodule

// ===== tb/tb_coalescing_task_queue_top.sv =====
`timescale 1ns / 1ps

module tb_coalescing_task_queue_top;
  import ctq_pkg::*;

  typedef struct {
    kind_e       kind;
    logic [15:0] handle;
    logic [15:0] owner;
    logic [15:0] tsk;
    logic        last;
    logic        closed;
    logic [4:0]  count;
  } queue_result_t;

  class queue_scoreboard;
    logic [15:0]   q_handle[DEPTH];
    logic [15:0]   q_owner[DEPTH];
    logic [15:0]   q_task[DEPTH];
    int unsigned   occupancy;
    bit            closed;
    queue_result_t pending[$];
    int            errors;
    int            results_seen;
    int            cancels_seen;

    function new();
      occupancy = 0;
      closed = 0;
      errors = 0;
      results_seen = 0;
      cancels_seen = 0;
    endfunction

    function void add_result(ref queue_result_t step[$], input kind_e k,
                             input logic [15:0] h, input logic [15:0] o,
                             input logic [15:0] t);
      queue_result_t r;
      r.kind = k;
      r.handle = h;
      r.owner = o;
      r.tsk = t;
      r.last = 0;
      r.closed = 0;
      r.count = 0;
      step.insert(step.size(), r);
    endfunction

    function void apply_push(ref queue_result_t step[$], input logic [2:0] rule,
                             input logic [15:0] o, input logic [15:0] t,
                             input logic [15:0] h);
      bit by_owner, by_task, hit, m;
      int unsigned w;
      if (closed) begin
        add_result(step, KIND_REJ_CLOSED, 0, 0, 0);
        return;
      end
      if (rule == RULE_OWNER || rule == RULE_TASK || rule == RULE_BOTH) begin
        by_owner = (rule == RULE_OWNER || rule == RULE_BOTH);
        by_task = (rule == RULE_TASK || rule == RULE_BOTH);
        hit = 0;
        for (int i = 0; i < occupancy; i++)
          if ((!by_owner || q_owner[i] == o) && (!by_task || q_task[i] == t)) hit = 1;
        if (hit) begin
          w = 0;
          hit = 0;
          for (int i = 0; i < occupancy; i++) begin
            m = (!by_owner || q_owner[i] == o) && (!by_task || q_task[i] == t);
            if (m) begin
              add_result(step, KIND_CANCEL, q_handle[i], q_owner[i], q_task[i]);
              if (!hit) begin
                q_handle[w] = h;
                q_owner[w] = o;
                q_task[w] = t;
                w++;
                hit = 1;
              end
            end else begin
              q_handle[w] = q_handle[i];
              q_owner[w] = q_owner[i];
              q_task[w] = q_task[i];
              w++;
            end
          end
          occupancy = w;
          add_result(step, KIND_ACCEPT, 0, 0, 0);
          return;
        end
        rule = RULE_APPEND;
      end
      if (occupancy >= DEPTH) begin
        add_result(step, KIND_REJ_FULL, 0, 0, 0);
        return;
      end
      if (rule == RULE_PREPEND) begin
        for (int i = occupancy; i > 0; i--) begin
          q_handle[i] = q_handle[i-1];
          q_owner[i] = q_owner[i-1];
          q_task[i] = q_task[i-1];
        end
        q_handle[0] = h;
        q_owner[0] = o;
        q_task[0] = t;
      end else begin
        q_handle[occupancy] = h;
        q_owner[occupancy] = o;
        q_task[occupancy] = t;
      end
      occupancy++;
      add_result(step, KIND_ACCEPT, 0, 0, 0);
    endfunction

    function void note_command(logic [1:0] action, logic [2:0] rule, logic [15:0] o,
                               logic [15:0] t, logic [15:0] h, logic clr);
      queue_result_t step[$];
      if (action == ACT_PUSH) begin
        apply_push(step, rule, o, t, h);
      end else if (action == ACT_POP) begin
        if (occupancy == 0) begin
          add_result(step, KIND_POP_EMPTY, 0, 0, 0);
        end else begin
          add_result(step, KIND_POPPED, q_handle[0], q_owner[0], q_task[0]);
          for (int i = 1; i < occupancy; i++) begin
            q_handle[i-1] = q_handle[i];
            q_owner[i-1] = q_owner[i];
            q_task[i-1] = q_task[i];
          end
          occupancy--;
        end
      end else if (action == ACT_CLOSE) begin
        closed = 1;
        if (clr) begin
          for (int i = 0; i < occupancy; i++)
            add_result(step, KIND_CANCEL, q_handle[i], q_owner[i], q_task[i]);
          occupancy = 0;
        end
        add_result(step, KIND_CLOSE_DONE, 0, 0, 0);
      end
      foreach (step[k]) begin
        step[k].last = (k == step.size() - 1);
        step[k].closed = closed;
        step[k].count = occupancy[4:0];
        pending.insert(pending.size(), step[k]);
      end
    endfunction

    function void check_result(logic [2:0] kind, logic [15:0] h, logic [15:0] o,
                               logic [15:0] t, logic last, logic qc, logic [4:0] cnt);
      queue_result_t e;
      results_seen++;
      if (kind == KIND_CANCEL) cancels_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result transfer, kind %0d", kind);
        errors++;
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (kind !== e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, kind);
        errors++;
      end
      if (h !== e.handle) begin
        $error("out_handle: expected %h, actual %h", e.handle, h);
        errors++;
      end
      if (o !== e.owner) begin
        $error("out_owner: expected %h, actual %h", e.owner, o);
        errors++;
      end
      if (t !== e.tsk) begin
        $error("out_task: expected %h, actual %h", e.tsk, t);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, last);
        errors++;
      end
      if (qc !== e.closed) begin
        $error("queue_closed: expected %0d, actual %0d", e.closed, qc);
        errors++;
      end
      if (cnt !== e.count) begin
        $error("entry_count: expected %0d, actual %0d", e.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned cycle_count;
  int unsigned commands_sent;
  queue_scoreboard board;

  ctq_cmd_if cmd_if ();
  ctq_res_if res_if ();

  coalescing_task_queue_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if.sink),
    .res_o (res_if.source)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_command(logic [1:0] action, logic [2:0] rule, logic [15:0] o,
                              logic [15:0] t, logic [15:0] h, logic clr);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.action <= action;
    cmd_if.push_rule <= rule;
    cmd_if.owner_id <= o;
    cmd_if.task_id <= t;
    cmd_if.task_handle <= h;
    cmd_if.clear_on_close <= clr;
    do @(posedge clk_i); while (!cmd_if.ready);
    board.note_command(action, rule, o, t, h, clr);
    commands_sent++;
  endtask

  task automatic send_random(int push_weight, bit allow_close);
    logic [1:0] action;
    logic [2:0] rule;
    logic [15:0] o, t;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < push_weight) action = ACT_PUSH;
    else if (pick < 97 || !allow_close) action = (pick < 95) ? ACT_POP : 2'd3;
    else action = ACT_CLOSE;
    rule = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                       : 3'($urandom_range(0, 4));
    if ($urandom_range(0, 7) == 0) begin
      o = 16'($urandom);
      t = 16'($urandom);
    end else begin
      o = 16'($urandom_range(0, 3)) ^ {16{pick[0]}};
      t = 16'($urandom_range(0, 3)) ^ {16{pick[1]}};
    end
    send_command(action, rule, o, t, 16'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      board.check_result(res_if.kind, res_if.out_handle, res_if.out_owner,
                         res_if.out_task, res_if.last, res_if.queue_closed,
                         res_if.entry_count);
    end
  end

  initial begin
    int phase_weight;
    board = new();
    commands_sent = 0;
    rst_ni = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.action = '0;
    cmd_if.push_rule = '0;
    cmd_if.owner_id = '0;
    cmd_if.task_id = '0;
    cmd_if.task_handle = '0;
    cmd_if.clear_on_close = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(ACT_POP, RULE_APPEND, 16'h0, 16'h0, 16'h0, 1'b0);
    send_command(ACT_PUSH, RULE_APPEND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_command(ACT_PUSH, RULE_APPEND, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_command(ACT_PUSH, RULE_PREPEND, 16'h1234, 16'h0000, 16'hA5A5, 1'b0);
    send_command(ACT_PUSH, RULE_APPEND, 16'h1234, 16'hFFFF, 16'h5A5A, 1'b0);
    send_command(ACT_PUSH, RULE_OWNER, 16'h1234, 16'h0007, 16'h0101, 1'b0);
    send_command(ACT_PUSH, RULE_TASK, 16'h0042, 16'hFFFF, 16'h0202, 1'b0);
    send_command(ACT_PUSH, RULE_BOTH, 16'h0000, 16'h0000, 16'h0303, 1'b0);
    send_command(ACT_PUSH, RULE_BOTH, 16'h7777, 16'h8888, 16'h0404, 1'b0);
    send_command(ACT_PUSH, 3'd5, 16'h0001, 16'h0002, 16'h0505, 1'b0);
    send_command(ACT_PUSH, 3'd7, 16'h0001, 16'h0002, 16'h0707, 1'b0);
    send_command(2'd3, RULE_APPEND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_command(ACT_PUSH, RULE_TASK, 16'h9999, 16'h0002, 16'h0808, 1'b0);
    send_command(ACT_POP, RULE_APPEND, 16'h0, 16'h0, 16'h0, 1'b0);
    send_command(ACT_POP, RULE_APPEND, 16'h0, 16'h0, 16'h0, 1'b0);

    cmd_if.valid <= 1'b0;
    wait_drained();

    for (int n = 0; n < 150; n++) begin
      phase_weight = ((n / 30) % 2 == 0) ? 85 : 35;
      send_random(phase_weight, 1'b0);
    end

    send_command(ACT_CLOSE, RULE_APPEND, 16'h0, 16'h0, 16'h0, 1'b1);
    for (int n = 0; n < 10; n++) send_random(60, 1'b0);
    send_command(ACT_CLOSE, RULE_APPEND, 16'h0, 16'h0, 16'h0, 1'b0);
    for (int n = 0; n < 10; n++) send_random(50, 1'b1);
    send_command(ACT_CLOSE, RULE_APPEND, 16'h0, 16'h0, 16'h0, 1'b1);
    cmd_if.valid <= 1'b0;

    wait_drained();
    repeat (60) @(posedge clk_i);
    $display("Sent %0d commands (pushes under all rules, pops, closes); checked %0d results",
             commands_sent, board.results_seen);
    $display("including %0d cancellations.", board.cancels_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
